FILE: sv/tlb_pkg.sv
package tlb_pkg;

	// Light state: bit 2 marks the shortened twin, bits 1..0 are the phase
	typedef enum logic [2:0] {
		ST_GREEN    = 3'b000,
		ST_YELLOW   = 3'b001,
		ST_RED      = 3'b010,
		ST_BLINK    = 3'b011,
		ST_GREEN_S  = 3'b100,
		ST_YELLOW_S = 3'b101,
		ST_RED_S    = 3'b110,
		ST_BLINK_S  = 3'b111
	} light_t;

	// Phase codes as shown on the result
	localparam logic [1:0] PH_GREEN  = 2'd0;
	localparam logic [1:0] PH_YELLOW = 2'd1;
	localparam logic [1:0] PH_RED    = 2'd2;
	localparam logic [1:0] PH_BLINK  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_BUTTON_ENABLE = 3'd0;
	localparam logic [2:0] CFG_RED_SECONDS   = 3'd1;
	localparam logic [2:0] CFG_GREEN_MS      = 3'd2;
	localparam logic [2:0] CFG_YELLOW_MS     = 3'd3;
	localparam logic [2:0] CFG_BLINK_MS      = 3'd4;

	localparam int ELAPSED_W = 20;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [ELAPSED_W-1:0] MS_PER_SECOND = 20'd1000;

	// Reset values of the configuration
	localparam logic        RST_BUTTON_ENABLE = 1'b1;
	localparam logic [19:0] RST_RED_MS        = 20'd5000;
	localparam logic [15:0] RST_GREEN_MS      = 16'd5000;
	localparam logic [15:0] RST_YELLOW_MS     = 16'd2000;
	localparam logic [15:0] RST_BLINK_MS      = 16'd3000;

	// Configuration as seen by the state machine
	typedef struct packed {
		logic                 button_enable;
		logic [ELAPSED_W-1:0] red_ms;
		logic [15:0]          green_ms;
		logic [15:0]          yellow_ms;
		logic [15:0]          blink_ms;
	} cfg_t;

endpackage

FILE: sv/tlb_cfg.sv
module tlb_cfg
	import tlb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	logic                 button_enable_q;
	logic [ELAPSED_W-1:0] red_ms_q;
	logic [15:0]          green_ms_q;
	logic [15:0]          yellow_ms_q;
	logic [15:0]          blink_ms_q;

	// Store writes; convert red seconds to milliseconds on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_enable_q <= RST_BUTTON_ENABLE;
			red_ms_q        <= RST_RED_MS;
			green_ms_q      <= RST_GREEN_MS;
			yellow_ms_q     <= RST_YELLOW_MS;
			blink_ms_q      <= RST_BLINK_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUTTON_ENABLE: button_enable_q <= cfg_wdata[0];
				CFG_RED_SECONDS:   red_ms_q <= ELAPSED_W'(cfg_wdata[9:0]) * MS_PER_SECOND;
				CFG_GREEN_MS:      green_ms_q <= cfg_wdata;
				CFG_YELLOW_MS:     yellow_ms_q <= cfg_wdata;
				CFG_BLINK_MS:      blink_ms_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.button_enable = button_enable_q;
	assign cfg.red_ms        = red_ms_q;
	assign cfg.green_ms      = green_ms_q;
	assign cfg.yellow_ms     = yellow_ms_q;
	assign cfg.blink_ms      = blink_ms_q;

endmodule

FILE: sv/tlb_core.sv
module tlb_core
	import tlb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       button_pressed,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [1:0] phase,
	output logic       shortened
);

	light_t               state_q, state_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [ELAPSED_W-1:0] phase_time;
	logic                 press;
	logic                 accept;
	logic                 out_valid_q;
	logic [1:0]           phase_q, phase_d;
	logic                 shortened_q, shortened_d;

	// Take a new tick whenever the result register is empty or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Saturating tick count
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	// Length of the current phase
	always_comb begin
		case (state_q)
			ST_GREEN, ST_GREEN_S:   phase_time = ELAPSED_W'(cfg.green_ms);
			ST_YELLOW, ST_YELLOW_S: phase_time = ELAPSED_W'(cfg.yellow_ms);
			ST_BLINK, ST_BLINK_S:   phase_time = ELAPSED_W'(cfg.blink_ms);
			ST_RED:                 phase_time = cfg.red_ms;
			ST_RED_S:               phase_time = cfg.red_ms >> 2;
			default:                phase_time = cfg.red_ms;
		endcase
	end

	assign press = button_pressed && cfg.button_enable;

	// Next state: a press in blink, yellow or red shortens without clearing the count, else timed move
	always_comb begin
		state_d   = state_q;
		elapsed_d = elapsed_inc;
		case (state_q)
			ST_BLINK, ST_YELLOW, ST_RED: begin
				if (press) begin
					state_d = light_t'({1'b1, state_q[1:0]});
				end else if (elapsed_inc > phase_time) begin
					case (state_q)
						ST_BLINK:  state_d = ST_YELLOW;
						ST_YELLOW: state_d = ST_RED;
						default:   state_d = ST_GREEN;
					endcase
					elapsed_d = '0;
				end
			end
			default: begin
				if (elapsed_inc > phase_time) begin
					case (state_q)
						ST_GREEN:    state_d = ST_BLINK;
						ST_GREEN_S:  state_d = ST_BLINK_S;
						ST_BLINK_S:  state_d = ST_YELLOW_S;
						ST_YELLOW_S: state_d = ST_RED_S;
						default:     state_d = ST_GREEN;
					endcase
					elapsed_d = '0;
				end
			end
		endcase
	end

	// Outputs: decode the new state into the result fields
	always_comb begin
		case (state_d)
			ST_GREEN, ST_GREEN_S:   phase_d = PH_GREEN;
			ST_YELLOW, ST_YELLOW_S: phase_d = PH_YELLOW;
			ST_RED, ST_RED_S:       phase_d = PH_RED;
			ST_BLINK, ST_BLINK_S:   phase_d = PH_BLINK;
			default:                phase_d = PH_GREEN;
		endcase
		shortened_d = state_d[2];
	end

	// Advance the state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_GREEN;
			elapsed_q <= '0;
		end else if (accept) begin
			state_q   <= state_d;
			elapsed_q <= elapsed_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// Result payload: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			phase_q     <= phase_d;
			shortened_q <= shortened_d;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign phase     = phase_q;
	assign shortened = shortened_q;

endmodule

FILE: sv/traffic_light_button_fsm.sv
// Traffic light controller with pedestrian button, one tick per transaction.
//
// Input stream (s_*): one transaction is one millisecond tick; s_tdata[0]
// carries the button level. Output stream (m_*): one transaction per tick
// with the light after that tick: m_tdata[1:0] phase (0 green, 1 yellow,
// 2 red, 3 blinking green), m_tdata[2] shortened flag.
// Configuration: cfg_we/cfg_index/cfg_wdata write button_enable, red_seconds,
// green_ms, yellow_ms and blink_ms (indexes 0..4); write only while idle.
//
// The state update for a tick is combinational logic between the state
// registers and the result register. Throughput is one tick per cycle
// while the receiver does not stall.
// Reset puts the light in green, not shortened, clears the elapsed count,
// loads the configuration defaults and empties the result register.
// When the receiver stalls, the result is held in the result register and
// s_tready drops until that result is taken; a tick is taken in the same
// cycle the waiting result leaves.
module traffic_light_button_fsm
	import tlb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] button_pressed, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [1:0] phase, [2] shortened, [7:3] zero
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t       cfg;
	logic [1:0] phase;
	logic       shortened;

	tlb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tlb_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.button_pressed (s_tdata[0]),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.phase          (phase),
		.shortened      (shortened)
	);

	assign m_tdata = {5'd0, shortened, phase};

endmodule

FILE: sv/tlb_checker.sv
module tlb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Accept a tick exactly when the result slot frees up
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow result register");

	// Every accepted tick gives a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted tick gave no result");

	// No result appears without an accepted tick
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result without accepted tick");

	// Padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] == 5'd0)
		else $error("padding bits set");

endmodule

bind traffic_light_button_fsm tlb_checker u_tlb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
